// ----- src/scm_pkg.sv -----
// Package: types and constants for the SCCB register master.
`timescale 1ns / 1ps
`default_nettype none

package scm_pkg;

  localparam int unsigned DelayWidth = 16;

  localparam logic [7:0]  DevAddrReset    = 8'h42;
  localparam logic [15:0] DelayTicksReset = 16'd1;

  localparam logic       CfgDevAddr    = 1'b0;
  localparam logic       CfgDelayTicks = 1'b1;

  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusNoAckAddr = 2'd1;
  localparam logic [1:0] StatusNoAckReg  = 2'd2;
  localparam logic [1:0] StatusNoAckData = 2'd3;

  typedef enum logic [4:0] {
    PhIdle = 5'd0,
    PhS1   = 5'd1,
    PhS2   = 5'd2,
    PhWlo  = 5'd3,
    PhWhi  = 5'd4,
    PhAlo  = 5'd5,
    PhAhi  = 5'd6,
    PhGap  = 5'd7,
    PhP1   = 5'd8,
    PhP2   = 5'd9,
    PhP3   = 5'd10,
    PhRgap = 5'd11,
    PhRlo  = 5'd12,
    PhRhi  = 5'd13,
    PhN1   = 5'd14,
    PhN2   = 5'd15,
    PhN3   = 5'd16,
    PhN4   = 5'd17
  } phase_e;

  typedef enum logic [1:0] {
    StgAddr   = 2'd0,
    StgReg    = 2'd1,
    StgData   = 2'd2,
    StgRdAddr = 2'd3
  } stage_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } scm_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rd_data;
  } scm_out_t;

  // bit 1 = SCL, bit 0 = SDA; data phases take SDA from the shift byte
  function automatic logic [1:0] phase_lines(phase_e ph);
    logic [1:0] lv;
    case (ph)
      PhIdle:  lv = 2'b11;
      PhS1:    lv = 2'b11;
      PhS2:    lv = 2'b10;
      PhAlo:   lv = 2'b01;
      PhAhi:   lv = 2'b11;
      PhGap:   lv = 2'b01;
      PhP1:    lv = 2'b00;
      PhP2:    lv = 2'b10;
      PhP3:    lv = 2'b11;
      PhRgap:  lv = 2'b11;
      PhRlo:   lv = 2'b01;
      PhRhi:   lv = 2'b11;
      PhN1:    lv = 2'b01;
      PhN2:    lv = 2'b11;
      PhN3:    lv = 2'b01;
      PhN4:    lv = 2'b00;
      default: lv = 2'b11;
    endcase
    return lv;
  endfunction

endpackage

`default_nettype wire

// ----- src/sccb_register_master_unit.sv -----
// Top level: tick-driven SCCB register master with registered result stage.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (scm_in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (scm_out_t)
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
//  One tick per clock cycle while the result register can take it: each transfer updates the sequencer.
//  The result register is loaded by each tick and holds its outcome from the cycle after that tick.
//  A tick is taken whenever the result register is empty or being drained.
//  Reset returns the sequencer to idle with both lines high; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sccb_register_master_unit
  import scm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire scm_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output scm_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [7:0]            dev_addr_q;
  logic [15:0]           delay_ticks_q;
  phase_e                phase_q, phase_d;
  stage_e                stage_q, stage_d;
  logic [2:0]            bit_count_q, bit_count_d;
  logic [7:0]            shift_byte_q, shift_byte_d;
  logic [DelayWidth-1:0] delay_count_q, delay_count_d;
  logic                  is_read_q, is_read_d;
  logic [7:0]            held_reg_q, held_reg_d;
  logic [7:0]            held_wdata_q, held_wdata_d;
  logic [1:0]            status_q, status_d;
  logic [7:0]            read_byte_q, read_byte_d;
  logic [1:0]            lines_q, lines_d;
  logic                  out_valid_q;
  scm_out_t              out_q, out_d;

  logic [DelayWidth-1:0] interval_raw;
  logic [DelayWidth-1:0] interval;
  logic [DelayWidth:0]   count_inc;
  logic                  in_xfer;
  logic                  busy;
  logic                  done;
  logic                  sda;
  logic [1:0]            tick_lines;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign sda         = in_data_i.sda_in;

  assign interval_raw = DelayWidth'(delay_ticks_q);
  assign interval     = (interval_raw == '0) ? DelayWidth'(1) : interval_raw;

  always_comb begin
    phase_d       = phase_q;
    stage_d       = stage_q;
    bit_count_d   = bit_count_q;
    shift_byte_d  = shift_byte_q;
    delay_count_d = delay_count_q;
    is_read_d     = is_read_q;
    held_reg_d    = held_reg_q;
    held_wdata_d  = held_wdata_q;
    status_d      = status_q;
    read_byte_d   = read_byte_q;
    lines_d       = lines_q;
    busy          = 1'b0;
    done          = 1'b0;
    count_inc     = '0;

    if (phase_q == PhIdle &&
        (in_data_i.req_type == ReqWrite || in_data_i.req_type == ReqRead)) begin
      is_read_d     = (in_data_i.req_type == ReqRead);
      held_reg_d    = in_data_i.reg_addr;
      held_wdata_d  = in_data_i.wr_data;
      stage_d       = StgAddr;
      bit_count_d   = '0;
      delay_count_d = '0;
      phase_d       = PhS1;
    end

    if (phase_d != PhIdle) begin
      if (phase_d == PhWlo || phase_d == PhWhi) begin
        lines_d = {phase_d == PhWhi, shift_byte_d[7]};
      end else begin
        lines_d = phase_lines(phase_d);
      end
      busy      = 1'b1;
      count_inc = {1'b0, delay_count_d} + 1'b1;
      if (count_inc >= {1'b0, interval}) begin
        delay_count_d = '0;
        case (phase_d)
          PhS1: phase_d = PhS2;
          PhS2: begin
            shift_byte_d = (stage_d == StgRdAddr) ? dev_addr_q + 8'd1 : dev_addr_q;
            bit_count_d  = '0;
            phase_d      = PhWlo;
          end
          PhWlo: phase_d = PhWhi;
          PhWhi: begin
            shift_byte_d = {shift_byte_d[6:0], 1'b0};
            bit_count_d  = bit_count_d + 3'd1;
            phase_d      = (bit_count_d == '0) ? PhAlo : PhWlo;
          end
          PhAlo: phase_d = PhAhi;
          PhAhi: begin
            if (sda) begin
              case (stage_d)
                StgAddr: status_d = StatusNoAckAddr;
                StgReg:  status_d = StatusNoAckReg;
                default: status_d = StatusNoAckData;
              endcase
              lines_d = 2'b01;
              phase_d = PhIdle;
              done    = 1'b1;
            end else begin
              case (stage_d)
                StgAddr: begin
                  stage_d      = StgReg;
                  shift_byte_d = held_reg_d;
                  bit_count_d  = '0;
                  phase_d      = PhGap;
                end
                StgReg: begin
                  if (is_read_d) begin
                    phase_d = PhP1;
                  end else begin
                    stage_d      = StgData;
                    shift_byte_d = held_wdata_d;
                    bit_count_d  = '0;
                    phase_d      = PhGap;
                  end
                end
                StgData: phase_d = PhP1;
                default: phase_d = PhGap;
              endcase
            end
          end
          PhGap: begin
            if (stage_d == StgRdAddr) begin
              shift_byte_d = '0;
              bit_count_d  = '0;
              phase_d      = PhRlo;
            end else begin
              phase_d = PhWlo;
            end
          end
          PhRlo: phase_d = PhRhi;
          PhRhi: begin
            shift_byte_d = {shift_byte_d[6:0], sda};
            bit_count_d  = bit_count_d + 3'd1;
            if (bit_count_d == '0) begin
              read_byte_d = shift_byte_d;
              phase_d     = PhN1;
            end else begin
              phase_d = PhRlo;
            end
          end
          PhN1: phase_d = PhN2;
          PhN2: phase_d = PhN3;
          PhN3: phase_d = PhN4;
          PhN4: phase_d = PhP1;
          PhP1: phase_d = PhP2;
          PhP2: phase_d = PhP3;
          PhP3: begin
            if (stage_d == StgReg) begin
              phase_d = PhRgap;
            end else begin
              status_d = StatusOk;
              lines_d  = 2'b11;
              phase_d  = PhIdle;
              done     = 1'b1;
            end
          end
          PhRgap: begin
            stage_d = StgRdAddr;
            phase_d = PhS1;
          end
          default: phase_d = PhIdle;
        endcase
      end else begin
        delay_count_d = count_inc[DelayWidth-1:0];
      end
    end

    out_d.scl_out   = tick_lines[1];
    out_d.sda_drive = tick_lines[0];
    out_d.busy_res  = busy;
    out_d.done_res  = done;
    out_d.status    = status_d;
    out_d.rd_data   = read_byte_d;
  end

  // line levels of this tick: those set on entry to the active phase
  always_comb begin
    if (phase_q == PhIdle &&
        !(in_data_i.req_type == ReqWrite || in_data_i.req_type == ReqRead)) begin
      tick_lines = lines_q;
    end else if (phase_q == PhIdle) begin
      tick_lines = phase_lines(PhS1);
    end else if (phase_q == PhWlo || phase_q == PhWhi) begin
      tick_lines = {phase_q == PhWhi, shift_byte_q[7]};
    end else begin
      tick_lines = phase_lines(phase_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DevAddrReset;
      delay_ticks_q <= DelayTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDevAddr:    dev_addr_q    <= cfg_wdata_i[7:0];
        CfgDelayTicks: delay_ticks_q <= cfg_wdata_i;
        default:       dev_addr_q    <= dev_addr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      stage_q       <= StgAddr;
      bit_count_q   <= '0;
      shift_byte_q  <= '0;
      delay_count_q <= '0;
      is_read_q     <= 1'b0;
      held_reg_q    <= '0;
      held_wdata_q  <= '0;
      status_q      <= StatusOk;
      read_byte_q   <= '0;
      lines_q       <= 2'b11;
    end else if (in_xfer) begin
      phase_q       <= phase_d;
      stage_q       <= stage_d;
      bit_count_q   <= bit_count_d;
      shift_byte_q  <= shift_byte_d;
      delay_count_q <= delay_count_d;
      is_read_q     <= is_read_d;
      held_reg_q    <= held_reg_d;
      held_wdata_q  <= held_wdata_d;
      status_q      <= status_d;
      read_byte_q   <= read_byte_d;
      lines_q       <= lines_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> out_q.busy_res)
    else $error("done without busy");

  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && phase_q == PhIdle && in_data_i.req_type != ReqWrite &&
    in_data_i.req_type != ReqRead |=> phase_q == PhIdle)
    else $error("sequencer left idle without a request");

  a_active_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && phase_q != PhIdle |=> out_valid_q && out_q.busy_res)
    else $error("active tick not reported busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && phase_q == PhIdle && in_data_i.req_type == ReqWrite
    |=> out_q.busy_res && out_q.scl_out && out_q.sda_drive)
    else $error("start tick not driven");

endmodule

`default_nettype wire
